FILE: sv/text_console_cursor_control_defines.svh
// Assertion macros for the text console cursor control block.
// Included by every RTL file that carries concurrent assertions; no dependencies.
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define TCCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks an implication on every rising clock edge outside reset.
`define TCCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TCCC_ASSERT(lbl, prop, msg)
`define TCCC_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/tccc_pkg.sv
// Shared types and constants for the text console cursor control block.
// Used by the front, queue, back and top-level modules; no dependencies.
package tccc_pkg;

  // Geometry and field widths.
  localparam int unsigned CoordW     = 12;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned CellW      = 8;
  localparam int unsigned CellH      = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes with special meaning.
  localparam logic [CodeW-1:0] CodeNewline   = 8'd10;
  localparam logic [CodeW-1:0] CodeBackspace = 8'd8;
  localparam logic [CodeW-1:0] CodeSpace     = 8'd32;

  // Reset values of the screen size registers.
  localparam logic [CoordW-1:0] ScreenWidthRst  = 12'd1024;
  localparam logic [CoordW-1:0] ScreenHeightRst = 12'd768;

  // Configuration register indexes.
  typedef enum logic {
    RegScreenWidth  = 1'b0,
    RegScreenHeight = 1'b1
  } reg_idx_e;

  // Result command codes.
  typedef enum logic {
    CmdDraw   = 1'b0,
    CmdScroll = 1'b1
  } cmd_e;

  // One classified item as handed from the front to the back.
  typedef struct packed {
    logic              has_draw;
    logic [CodeW-1:0]  glyph;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              has_scroll;
  } entry_t;

endpackage

FILE: sv/tccc_queue.sv
// Two-entry queue of classified items between the front and the back.
// Depends on tccc_pkg and the assertion macros header.
`include "text_console_cursor_control_defines.svh"

module tccc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tccc_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output tccc_pkg::entry_t rdata_o,
  output logic            empty_o
);
  import tccc_pkg::*;

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  // Status flags come straight from the fill count.
  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `TCCC_ASSERT(a_count_bound, count_q <= QueueCntW'(QueueDepth), "queue count overflow")
  `TCCC_ASSERT_IMP(a_no_push_full, push_i, !full_o, "push into a full queue")
  `TCCC_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "pop from an empty queue")

endmodule

FILE: sv/tccc_front.sv
// Front end: holds the screen size registers and the cursor, accepts one
// character item per cycle unless q_full_i, classifies it. Depends on tccc_pkg.
module tccc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [tccc_pkg::CoordW-1:0]   cfg_wdata_i,
  input  logic                          push_i,
  input  logic [tccc_pkg::CodeW-1:0]    char_code_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output tccc_pkg::entry_t              q_wdata_o
);
  import tccc_pkg::*;

  logic [CoordW-1:0] width_q, height_q;
  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;

  logic [CoordW:0]   x_cur, y_cur, x_new, y_new, x_adv, y_fin;
  logic [CoordW-1:0] whole_w;
  logic              is_nl, is_bs, scroll, accept;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else if (cfg_we_i) begin
      if (reg_idx_e'(cfg_addr_i) == RegScreenWidth) begin
        width_q <= cfg_wdata_i;
      end else begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // Cursor update for the incoming character.
  always_comb begin
    x_cur   = {1'b0, col_q};
    y_cur   = {1'b0, row_q};
    is_nl   = (char_code_i == CodeNewline);
    is_bs   = (char_code_i == CodeBackspace);
    whole_w = {width_q[CoordW-1:3], 3'b000};
    x_adv   = x_cur + (CoordW+1)'(CellW);
    x_new   = x_cur;
    y_new   = y_cur;
    if (is_nl) begin
      x_new = '0;
      y_new = y_cur + (CoordW+1)'(CellH);
    end else if (is_bs) begin
      if (x_cur >= (CoordW+1)'(CellW)) begin
        x_new = x_cur - (CoordW+1)'(CellW);
      end else if (y_cur >= (CoordW+1)'(CellH)) begin
        y_new = y_cur - (CoordW+1)'(CellH);
        x_new = (|width_q[CoordW-1:3]) ? {1'b0, whole_w - CoordW'(CellW)} : '0;
      end
    end else begin
      if (({1'b0, x_adv} + (CoordW+2)'(CellW)) > {2'b00, width_q}) begin
        x_new = '0;
        y_new = y_cur + (CoordW+1)'(CellH);
      end else begin
        x_new = x_adv;
      end
    end
    // A single scroll when the next row would run past the bottom.
    scroll = (({1'b0, y_new} + (CoordW+2)'(CellH)) > {2'b00, height_q});
    y_fin  = y_new;
    if (scroll && (y_new >= (CoordW+1)'(CellH))) begin
      y_fin = y_new - (CoordW+1)'(CellH);
    end
  end

  // Build the queue entry; a draw uses the position before any scroll.
  always_comb begin
    q_wdata_o.has_draw   = !is_nl;
    q_wdata_o.glyph      = is_bs ? CodeSpace : char_code_i;
    q_wdata_o.x          = is_bs ? x_new[CoordW-1:0] : col_q;
    q_wdata_o.y          = is_bs ? y_new[CoordW-1:0] : row_q;
    q_wdata_o.has_scroll = scroll;
  end

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept && (!is_nl || scroll);
  assign col_d    = accept ? x_new[CoordW-1:0] : col_q;
  assign row_d    = accept ? y_fin[CoordW-1:0] : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: sv/tccc_back.sv
// Back end: expands each queued entry into one or two result items and
// holds them in an output register. Depends on tccc_pkg and the macros header.
`include "text_console_cursor_control_defines.svh"

module tccc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tccc_pkg::entry_t            q_rdata_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic                        pop,
  output logic                        empty,
  output logic                        command_o,
  output logic [tccc_pkg::CodeW-1:0]  glyph_code_o,
  output logic [tccc_pkg::CoordW-1:0] pos_x_o,
  output logic [tccc_pkg::CoordW-1:0] pos_y_o,
  output logic                        last_o
);
  import tccc_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic              phase_q, phase_d;
  cmd_e              cmd_q, cmd_d;
  logic [CodeW-1:0]  glyph_q, glyph_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d;
  logic              last_q, last_d;
  logic              load, done;

  // Pick the next result of the head entry: the draw first, then the scroll.
  always_comb begin
    load = !q_empty_i && (!out_valid_q || pop);
    if (!phase_q && q_rdata_i.has_draw) begin
      cmd_d   = CmdDraw;
      glyph_d = q_rdata_i.glyph;
      x_d     = q_rdata_i.x;
      y_d     = q_rdata_i.y;
      done    = !q_rdata_i.has_scroll;
    end else begin
      cmd_d   = CmdScroll;
      glyph_d = '0;
      x_d     = '0;
      y_d     = '0;
      done    = 1'b1;
    end
    last_d      = done;
    q_pop_o     = load && done;
    phase_d     = load ? !done : phase_q;
    out_valid_d = load ? 1'b1 : (pop ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q   <= cmd_d;
      glyph_q <= glyph_d;
      x_q     <= x_d;
      y_q     <= y_d;
      last_q  <= last_d;
    end
  end

  assign empty        = !out_valid_q;
  assign command_o    = cmd_q;
  assign glyph_code_o = glyph_q;
  assign pos_x_o      = x_q;
  assign pos_y_o      = y_q;
  assign last_o       = last_q;

  `TCCC_ASSERT_IMP(a_scroll_zero, out_valid_q && (cmd_q == CmdScroll),
                   (glyph_q == '0) && (x_q == '0) && (y_q == '0) && last_q,
                   "scroll item carries a non-zero payload")
  `TCCC_ASSERT_IMP(a_phase_head, phase_q, !q_empty_i,
                   "second half of an entry without a queued entry")
  `TCCC_ASSERT_IMP(a_phase_draw, phase_q,
                   out_valid_q && (cmd_q == CmdDraw) && !last_q,
                   "pending scroll not preceded by a draw")

endmodule

FILE: sv/text_console_cursor_control.sv
// Top level of the text console cursor control block.
// Depends on tccc_pkg, tccc_front, tccc_queue and tccc_back.
//
// Usage: character bytes enter on the push/full channel, one item per
// cycle while full is low. Newline, backspace and printable bytes move a
// pixel cursor on an 8x16-cell grid; each byte yields up to two result
// items (a draw, then a scroll), taken on the empty/pop channel with last
// set on the final one. A newline that does not scroll yields nothing.
// A byte's first result passes through the queue and then the output
// register. Throughput: one byte per cycle while each yields a single
// result and the receiver keeps popping; a byte that yields two holds
// the output register for both, and the two-entry queue between front
// and back absorbs the difference until full rises.
// Screen size is written through cfg_we_i/cfg_addr_i/cfg_wdata_i while
// the block is idle. Reset sets the screen to 1024x768, the cursor to the
// top-left corner and empties the queue and output register. When the
// receiver stalls, results wait in the output register and the queue,
// and full rises once both are occupied.
module text_console_cursor_control (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [tccc_pkg::CoordW-1:0] cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [tccc_pkg::CodeW-1:0]  char_code_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        command_o,
  output logic [tccc_pkg::CodeW-1:0]  glyph_code_o,
  output logic [tccc_pkg::CoordW-1:0] pos_x_o,
  output logic [tccc_pkg::CoordW-1:0] pos_y_o,
  output logic                        last_o
);
  import tccc_pkg::*;

  entry_t q_wdata, q_rdata;
  logic   q_push, q_pop, q_full, q_empty;

  // Front end: classification and cursor state.
  tccc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_wdata_o   (q_wdata)
  );

  // Decoupling queue.
  tccc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // Back end: result sequencing and output register.
  tccc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_rdata_i    (q_rdata),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .command_o    (command_o),
    .glyph_code_o (glyph_code_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .last_o       (last_o)
  );

  assign full = q_full;

endmodule

FILE: tb/text_console_cursor_control_test.sv
// Self-checking testbench for the text console cursor control block.
// Drives character bytes through a directed table, then through random screen sizes.
// Depends on tccc_pkg and text_console_cursor_control; checks commands against a cursor model.
`timescale 1ns / 1ps

module text_console_cursor_control_test;
  import tccc_pkg::*;

  localparam int QuietLimit   = 1000;
  localparam int DrainCycles  = 8;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 50;
  localparam int MaxReported  = 10;

  // One command as the block should produce it.
  typedef struct {
    cmd_e              cmd;
    logic [CodeW-1:0]  glyph;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
  } console_cmd_t;

  // One row of the directed table: a screen size change or a character item.
  typedef struct {
    bit                is_screen;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
    logic [CodeW-1:0]  code;
    bit                typed;
    console_cmd_t      want;
  } tab_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_addr_i  = RegScreenWidth;
  logic [CoordW-1:0] cfg_wdata_i = '0;
  logic              push        = 1'b0;
  logic [CodeW-1:0]  char_code_i = '0;
  logic              pop         = 1'b0;
  logic              full;
  logic              empty;
  logic              command_o;
  logic [CodeW-1:0]  glyph_code_o;
  logic [CoordW-1:0] pos_x_o;
  logic [CoordW-1:0] pos_y_o;
  logic              last_o;

  // Cursor model state and its copy of the screen size.
  int unsigned  scr_w;
  int unsigned  scr_h;
  int unsigned  cur_x;
  int unsigned  cur_y;
  console_cmd_t pending_cmds[$];
  tab_row_t     cmd_table[$];

  int push_gap_max = 8;
  int pop_gap_max  = 8;
  int fail_count   = 0;
  int chars_sent   = 0;
  int draws_seen   = 0;
  int scrolls_seen = 0;
  int sizes_used   = 1;
  int quiet_cycles = 0;

  text_console_cursor_control dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code_i),
    .empty        (empty),
    .pop          (pop),
    .command_o    (command_o),
    .glyph_code_o (glyph_code_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Appends one expected command to the queue.
  function automatic void queue_cmd(cmd_e cmd, logic [CodeW-1:0] glyph, int unsigned x,
                                    int unsigned y);
    console_cmd_t c;
    c.cmd   = cmd;
    c.glyph = glyph;
    c.x     = x[CoordW-1:0];
    c.y     = y[CoordW-1:0];
    c.last  = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  // Moves the cursor for one character and queues the commands it causes.
  function automatic int advance_cursor(logic [CodeW-1:0] code);
    int unsigned x;
    int unsigned y;
    int unsigned whole;
    int          n;
    x = cur_x;
    y = cur_y;
    n = 0;
    if (code == CodeNewline) begin
      x = 0;
      y = y + CellH;
    end else if (code == CodeBackspace) begin
      if (x >= CellW) begin
        x = x - CellW;
      end else if (y >= CellH) begin
        // Wrap to the last whole cell of the row above.
        whole = (scr_w / CellW) * CellW;
        y = y - CellH;
        x = (whole >= CellW) ? whole - CellW : 0;
      end
      queue_cmd(CmdDraw, CodeSpace, x, y);
      n++;
    end else begin
      queue_cmd(CmdDraw, code, x, y);
      n++;
      x = x + CellW;
      if (x + CellW > scr_w) begin
        x = 0;
        y = y + CellH;
      end
    end
    // At most one scroll per character, even if the cursor stays below the bottom.
    if (y + CellH > scr_h) begin
      if (y >= CellH) y = y - CellH;
      queue_cmd(CmdScroll, '0, 0, 0);
      n++;
    end
    if (n > 0) pending_cmds[pending_cmds.size()-1].last = 1'b1;
    cur_x = x % 4096;
    cur_y = y % 4096;
    return n;
  endfunction

  // An empty table row with every field cleared.
  function automatic tab_row_t blank_row();
    tab_row_t r;
    r.is_screen  = 1'b0;
    r.width      = '0;
    r.height     = '0;
    r.code       = '0;
    r.typed      = 1'b0;
    r.want.cmd   = CmdDraw;
    r.want.glyph = '0;
    r.want.x     = '0;
    r.want.y     = '0;
    r.want.last  = 1'b0;
    return r;
  endfunction

  function automatic void tab_char(logic [CodeW-1:0] code);
    tab_row_t r;
    r = blank_row();
    r.code = code;
    cmd_table.push_back(r);
  endfunction

  // A row whose first command is written out by hand.
  function automatic void tab_check(logic [CodeW-1:0] code, cmd_e cmd, logic [CodeW-1:0] glyph,
                                    logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic last);
    tab_row_t r;
    r = blank_row();
    r.code       = code;
    r.typed      = 1'b1;
    r.want.cmd   = cmd;
    r.want.glyph = glyph;
    r.want.x     = x;
    r.want.y     = y;
    r.want.last  = last;
    cmd_table.push_back(r);
  endfunction

  function automatic void tab_screen(logic [CoordW-1:0] w, logic [CoordW-1:0] h);
    tab_row_t r;
    r = blank_row();
    r.is_screen = 1'b1;
    r.width     = w;
    r.height    = h;
    cmd_table.push_back(r);
  endfunction

  // Offers one character item and updates the model once it is taken.
  task automatic send_char(logic [CodeW-1:0] code, bit typed, console_cmd_t want);
    int gap;
    int n;
    gap = $urandom_range(0, push_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (full);
    n = advance_cursor(code);
    if (typed && n > 0) pending_cmds[pending_cmds.size()-n] = want;
    chars_sent++;
  endtask

  // Waits until the block is idle, then writes both screen size registers.
  task automatic set_screen(logic [CoordW-1:0] w, logic [CoordW-1:0] h);
    push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegScreenWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_addr_i  <= RegScreenHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scr_w = w;
    scr_h = h;
    sizes_used++;
  endtask

  // Result side: takes commands with random stalls and compares each with the oldest expected.
  initial begin
    console_cmd_t want;
    int           gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, pop_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_cmds.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReported)
          $display("unexpected command: cmd=%0d glyph=%0d x=%0d y=%0d last=%0d",
                   command_o, glyph_code_o, pos_x_o, pos_y_o, last_o);
      end else begin
        want = pending_cmds.pop_front();
        if (want.cmd == CmdScroll) scrolls_seen++;
        else draws_seen++;
        if (command_o !== want.cmd || glyph_code_o !== want.glyph || pos_x_o !== want.x ||
            pos_y_o !== want.y || last_o !== want.last) begin
          fail_count++;
          if (fail_count <= MaxReported)
            $display("mismatch: expected cmd=%0d glyph=%0d x=%0d y=%0d last=%0d",
                     want.cmd, want.glyph, want.x, want.y, want.last,
                     ", got cmd=%0d glyph=%0d x=%0d y=%0d last=%0d",
                     command_o, glyph_code_o, pos_x_o, pos_y_o, last_o);
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles", QuietLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases over several screen sizes.
  initial begin
    console_cmd_t none;
    tab_row_t     row;
    int           r;
    logic [CodeW-1:0]  code;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    none  = '{cmd: CmdDraw, glyph: '0, x: '0, y: '0, last: 1'b0};
    scr_w = ScreenWidthRst;
    scr_h = ScreenHeightRst;
    cur_x = 0;
    cur_y = 0;

    // Reset screen: extremes of the byte, backspace at the top-left and across a row.
    tab_check(8'd65, CmdDraw, 8'd65, 12'd0, 12'd0, 1'b1);
    tab_check(CodeBackspace, CmdDraw, CodeSpace, 12'd0, 12'd0, 1'b1);
    tab_check(CodeBackspace, CmdDraw, CodeSpace, 12'd0, 12'd0, 1'b1);
    tab_check(8'd0, CmdDraw, 8'd0, 12'd0, 12'd0, 1'b1);
    tab_check(8'd255, CmdDraw, 8'd255, 12'd8, 12'd0, 1'b1);
    tab_char(CodeNewline);
    tab_check(CodeBackspace, CmdDraw, CodeSpace, 12'd1016, 12'd0, 1'b1);
    tab_check(8'd66, CmdDraw, 8'd66, 12'd1016, 12'd0, 1'b1);
    tab_char(8'd9);
    tab_char(8'd127);
    tab_char(8'd128);
    // Minimum height: a newline that scrolls, then a draw that does not.
    tab_screen(12'd1024, 12'd32);
    tab_check(CodeNewline, CmdScroll, 8'd0, 12'd0, 12'd0, 1'b1);
    tab_check(8'd67, CmdDraw, 8'd67, 12'd0, 12'd16, 1'b1);
    // Minimum width: a draw that wraps and scrolls gives two commands.
    tab_screen(12'd16, 12'd32);
    tab_check(8'd68, CmdDraw, 8'd68, 12'd8, 12'd16, 1'b0);
    // Screen narrower than a cell: the backspace wrap column saturates to zero.
    tab_screen(12'd4, 12'd32);
    tab_check(CodeBackspace, CmdDraw, CodeSpace, 12'd0, 12'd0, 1'b1);
    tab_char(8'd69);
    // Largest screen: wrap to the last whole cell and back.
    tab_screen(12'd4095, 12'd4095);
    tab_check(CodeBackspace, CmdDraw, CodeSpace, 12'd4080, 12'd0, 1'b1);
    tab_check(8'd70, CmdDraw, 8'd70, 12'd4080, 12'd0, 1'b1);
    tab_char(CodeNewline);
    tab_char(CodeNewline);
    // Shrinking the screen leaves the cursor below the bottom.
    tab_screen(12'd16, 12'd32);
    tab_char(8'd71);
    tab_char(CodeSpace);
    tab_char(CodeNewline);
    tab_char(CodeBackspace);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cmd_table[i]) begin
      row = cmd_table[i];
      if (row.is_screen) set_screen(row.width, row.height);
      else send_char(row.code, row.typed, row.want);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin w = 12'd16;   h = 12'd32;   end
        1: begin w = 12'd4095; h = 12'd4095; end
        2: begin
          w = CoordW'($urandom_range(0, 7));
          h = CoordW'($urandom_range(0, 31));
        end
        3: begin
          w = CoordW'($urandom_range(0, 4095));
          h = CoordW'($urandom_range(0, 4095));
        end
        default: begin
          w = CoordW'($urandom_range(16, 200));
          h = CoordW'($urandom_range(32, 160));
        end
      endcase
      set_screen(w, h);
      // Every third phase runs both sides flat out.
      push_gap_max = (p % 3 == 2) ? 0 : 8;
      pop_gap_max  = (p % 3 == 2) ? 0 : 8;
      repeat (PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 20) code = CodeNewline;
        else if (r < 40) code = CodeBackspace;
        else if (r < 45) code = CodeSpace;
        else code = CodeW'($urandom_range(0, 255));
        send_char(code, 1'b0, none);
      end
    end

    push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters over %0d screen sizes; checked %0d draws and %0d scrolls.",
             chars_sent, sizes_used, draws_seen, scrolls_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
